>>> sv/monotone_boundary_search_core_defines.svh
// Assertion macros for the monotone boundary search core.
`ifndef MONOTONE_BOUNDARY_SEARCH_CORE_DEFINES_SVH
`define MONOTONE_BOUNDARY_SEARCH_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define MBS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MBS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define MBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> sv/mbs_pkg.sv
// Types and constants for the monotone boundary search core.
package mbs_pkg;

    // Default width of the searched value
    localparam int VALUE_WIDTH_DEF = 32;

    // Width of the value and tag ports
    localparam int PORT_WIDTH = 32;

    // Search phase
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_FIRST  = 3'd1,
        PH_PLUS1  = 3'd2,
        PH_DOUBLE = 3'd3,
        PH_HALVE  = 3'd4,
        PH_BISECT = 3'd5
    } phase_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_PROBE    = 3'd0,
        ST_DONE     = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_NONE     = 3'd3,
        ST_IGNORED  = 3'd4
    } status_t;

endpackage

>>> sv/monotone_boundary_search_core.sv
// Monotone boundary search: exponential search then bisection over probe answers.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------
//  in      | input     | in_valid / in_stall | mode, start_value, probe_passed
//  out     | output    | out_valid/out_stall | status, probe_value, probe_tag, found_value
//  cfg     | input     | cfg_wr_en           | cfg_wr_data (probe_context)
//
// Each input transaction yields one result transaction, registered and shown in the cycle after acceptance.
// A new transaction is taken every cycle while in_stall is low; the single result register is the only
// stage, so throughput is one per cycle while out_stall is low.
// in_stall is high only while a result is held and out_stall is high.
// Reset (rst_n low, asynchronous) returns the search to idle and clears the state.
`include "monotone_boundary_search_core_defines.svh"

module monotone_boundary_search_core #(
    parameter int VALUE_WIDTH = mbs_pkg::VALUE_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [31:0] start_value,
    input  logic        probe_passed,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] probe_value,
    output logic [31:0] probe_tag,
    output logic [31:0] found_value
);

    localparam int VW = VALUE_WIDTH;
    localparam int PW = mbs_pkg::PORT_WIDTH;

    // State
    mbs_pkg::phase_t phase_reg, phase_next;
    logic [VW-1:0]   pend_reg, pend_next;
    logic [VW-1:0]   lp_reg, lp_next;
    logic [VW-1:0]   sf_reg, sf_next;
    logic [PW-1:0]   ctx_reg;

    // Result register
    logic              out_valid_reg;
    mbs_pkg::status_t  status_reg, status_next;
    logic [PW-1:0]     probe_value_reg, probe_value_next;
    logic [PW-1:0]     probe_tag_reg, probe_tag_next;
    logic [PW-1:0]     found_value_reg, found_value_next;

    logic              in_acc;
    logic              out_acc;

    // Datapath helpers
    logic [63:0]   start_wide;
    logic [VW-1:0] start_v;
    logic [VW-1:0] lp_upd, sf_upd;
    logic          bis_done;
    logic [VW-1:0] bis_mid;
    logic [VW-1:0] dbl_from;
    logic          dbl_over;
    logic [VW-1:0] dbl_val;
    logic [VW-1:0] req_val;
    logic [63:0]   req_wide;
    logic [63:0]   found_wide;

    // Handshake
    assign in_stall = out_valid_reg && out_stall;
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid_reg && !out_stall;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            ctx_reg <= cfg_wr_data;
        end
    end

    // Bracket candidates after applying this answer
    assign start_wide = 64'(start_value);
    assign start_v    = start_wide[VW-1:0];
    assign lp_upd     = probe_passed ? pend_reg : lp_reg;
    assign sf_upd     = probe_passed ? sf_reg : pend_reg;
    assign bis_done   = (({1'b0, lp_upd} + {{VW{1'b0}}, 1'b1}) == {1'b0, sf_upd});
    assign bis_mid    = lp_upd + ((sf_upd - lp_upd) >> 1);

    // Doubling step: after the plus-one probe it doubles from the largest pass
    assign dbl_from = (phase_reg == mbs_pkg::PH_PLUS1) ? lp_reg : pend_reg;
    assign dbl_over = dbl_from[VW-1];
    assign dbl_val  = (dbl_from == '0) ? VW'(2) : (dbl_from << 1);

    // Next state and result
    always_comb
    begin
        phase_next  = phase_reg;
        pend_next   = pend_reg;
        lp_next     = lp_reg;
        sf_next     = sf_reg;
        status_next = mbs_pkg::ST_IGNORED;
        req_val     = '0;

        if (!mode)
        begin
            phase_next  = mbs_pkg::PH_FIRST;
            req_val     = start_v;
            status_next = mbs_pkg::ST_PROBE;
        end
        else
        begin
            case (phase_reg)
                mbs_pkg::PH_FIRST:
                begin
                    if (probe_passed)
                    begin
                        lp_next = pend_reg;
                        if (&pend_reg)
                        begin
                            status_next = mbs_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            status_next = mbs_pkg::ST_PROBE;
                            phase_next  = mbs_pkg::PH_PLUS1;
                            req_val     = pend_reg + VW'(1);
                        end
                    end
                    else
                    begin
                        sf_next = pend_reg;
                        if (pend_reg == '0)
                        begin
                            status_next = mbs_pkg::ST_NONE;
                        end
                        else
                        begin
                            status_next = mbs_pkg::ST_PROBE;
                            phase_next  = mbs_pkg::PH_HALVE;
                            req_val     = pend_reg >> 1;
                        end
                    end
                end
                mbs_pkg::PH_PLUS1,
                mbs_pkg::PH_DOUBLE:
                begin
                    if (probe_passed)
                    begin
                        // plus-one pass keeps the largest pass unchanged
                        if (phase_reg == mbs_pkg::PH_DOUBLE)
                        begin
                            lp_next = pend_reg;
                        end
                        if (dbl_over)
                        begin
                            status_next = mbs_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            status_next = mbs_pkg::ST_PROBE;
                            phase_next  = mbs_pkg::PH_DOUBLE;
                            req_val     = dbl_val;
                        end
                    end
                    else
                    begin
                        sf_next = pend_reg;
                        if (bis_done)
                        begin
                            status_next = mbs_pkg::ST_DONE;
                        end
                        else
                        begin
                            status_next = mbs_pkg::ST_PROBE;
                            phase_next  = mbs_pkg::PH_BISECT;
                            req_val     = bis_mid;
                        end
                    end
                end
                mbs_pkg::PH_HALVE:
                begin
                    if (probe_passed)
                    begin
                        lp_next = pend_reg;
                        if (bis_done)
                        begin
                            status_next = mbs_pkg::ST_DONE;
                        end
                        else
                        begin
                            status_next = mbs_pkg::ST_PROBE;
                            phase_next  = mbs_pkg::PH_BISECT;
                            req_val     = bis_mid;
                        end
                    end
                    else
                    begin
                        sf_next = pend_reg;
                        if (pend_reg == '0)
                        begin
                            status_next = mbs_pkg::ST_NONE;
                        end
                        else
                        begin
                            status_next = mbs_pkg::ST_PROBE;
                            req_val     = pend_reg >> 1;
                        end
                    end
                end
                mbs_pkg::PH_BISECT:
                begin
                    lp_next = lp_upd;
                    sf_next = sf_upd;
                    if (bis_done)
                    begin
                        status_next = mbs_pkg::ST_DONE;
                    end
                    else
                    begin
                        status_next = mbs_pkg::ST_PROBE;
                        req_val     = bis_mid;
                    end
                end
                default:
                begin
                    // answer while idle: state unchanged
                    status_next = mbs_pkg::ST_IGNORED;
                end
            endcase

            // any final status ends the search
            if (status_next != mbs_pkg::ST_PROBE)
            begin
                phase_next = mbs_pkg::PH_IDLE;
            end
        end

        if (status_next == mbs_pkg::ST_PROBE)
        begin
            pend_next = req_val;
        end
    end

    // Result payload, zero in fields that do not apply
    assign req_wide   = 64'(req_val);
    assign found_wide = 64'(lp_upd);

    always_comb
    begin
        probe_value_next = '0;
        probe_tag_next   = '0;
        found_value_next = '0;
        if (status_next == mbs_pkg::ST_PROBE)
        begin
            probe_value_next = req_wide[PW-1:0];
            probe_tag_next   = ctx_reg;
        end
        if (status_next == mbs_pkg::ST_DONE)
        begin
            found_value_next = found_wide[PW-1:0];
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mbs_pkg::PH_IDLE;
            pend_reg  <= '0;
            lp_reg    <= '0;
            sf_reg    <= '0;
        end
        else if (in_acc)
        begin
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
            lp_reg    <= lp_next;
            sf_reg    <= sf_next;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_acc)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            status_reg      <= status_next;
            probe_value_reg <= probe_value_next;
            probe_tag_reg   <= probe_tag_next;
            found_value_reg <= found_value_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign probe_value = probe_value_reg;
    assign probe_tag   = probe_tag_reg;
    assign found_value = found_value_reg;

    // Checks
    `MBS_ASSERT_NEXT(a_result_follows, clk, rst_n, in_acc, out_valid_reg, "accepted transaction gave no result")
    `MBS_ASSERT_NEXT(a_start_first, clk, rst_n, in_acc && !mode, phase_reg == mbs_pkg::PH_FIRST, "start did not enter first probe")
    `MBS_ASSERT_IMPL(a_bracket_order, clk, rst_n, phase_reg == mbs_pkg::PH_BISECT, lp_reg < sf_reg, "bisection bracket out of order")
    `MBS_ASSERT_IMPL(a_tag_only_probe, clk, rst_n, out_valid_reg && (status_reg != mbs_pkg::ST_PROBE), probe_tag_reg == '0, "tag set on non-probe result")

endmodule
